FILE: hw/rtl/lpdr_pkg.sv
`timescale 1ns / 1ps

package lpdr_pkg;

  localparam int PAT_W        = 16;
  localparam int RUN_W        = 5;
  localparam int OFS_W        = 6;
  localparam int CNT_OUT_W    = 4;
  localparam int CNT_W        = 5;
  localparam int IDX_W        = 4;
  localparam int LEAD_W       = 4;
  localparam int DEF_MAX_DASH = 11;

  localparam logic [PAT_W-1:0] PAT_CLEAR    = 16'h0000;
  localparam logic [PAT_W-1:0] PAT_SET      = 16'hffff;
  localparam logic [PAT_W-1:0] PAT_DOT_ODD  = 16'h5555;
  localparam logic [PAT_W-1:0] PAT_DOT_EVEN = 16'haaaa;

  localparam logic [OFS_W-1:0] OFS_CLEAR    = 6'h3f;
  localparam logic [OFS_W-1:0] OFS_SET      = 6'h00;
  localparam logic [OFS_W-1:0] OFS_DOT_ODD  = 6'h01;
  localparam logic [OFS_W-1:0] OFS_DOT_EVEN = 6'h00;
  localparam logic [OFS_W-1:0] OFS_BASE     = 6'(PAT_W + 1);

  // Number of leading zero bits, PAT_W for an all-zero word.
  function automatic logic [CNT_W-1:0] lead_zeros(input logic [PAT_W-1:0] v);
    logic [CNT_W-1:0] n;
    logic             hit;
    n   = CNT_W'(PAT_W);
    hit = 1'b0;
    for (int i = PAT_W - 1; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = CNT_W'(PAT_W - 1 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [CNT_W-1:0] ones(input logic [PAT_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < PAT_W; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/line_pattern_to_dash_runs_top.sv
`timescale 1ns / 1ps

// Channel  | Handshake          | Payload
// ---------+--------------------+---------------------------------------------
// in       | in_valid, in_stall | line_pattern
// out      | out_valid,out_stall| run_length, dash_offset, element_count,
//          |                    | truncated, last
//
// Each input word yields one result word per run, so one pattern yields 1 to
// MAX_DASH_ELEMENTS result words; the four special patterns yield a single
// result word. The emitter produces one run length per cycle while the
// output is not stalled. A word goes input register, emitter, output register.
// Reset empties all three stages.
// A stalled output holds the emitter; the input register still takes a word when empty.

module line_pattern_to_dash_runs_top #(
  parameter int MAX_DASH_ELEMENTS = lpdr_pkg::DEF_MAX_DASH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lpdr_pkg::PAT_W-1:0]      line_pattern,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lpdr_pkg::RUN_W-1:0]      run_length,
  output logic [lpdr_pkg::OFS_W-1:0]      dash_offset,
  output logic [lpdr_pkg::CNT_OUT_W-1:0]  element_count,
  output logic                            truncated,
  output logic                            last
);

  import lpdr_pkg::*;

  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_DASH_ELEMENTS);

  logic             in_full;
  logic [PAT_W-1:0] in_pat;

  logic             e_busy;
  logic             e_fixed;
  logic             e_fixed_run;
  logic [PAT_W-1:0] e_word;
  logic             e_cur;
  logic [CNT_W-1:0] e_rem;
  logic [IDX_W-1:0] e_idx;
  logic [CNT_W-1:0] e_count;
  logic             e_trunc;
  logic [OFS_W-1:0] e_offset;

  logic             adv;
  logic             emit;
  logic             e_last;
  logic             e_done;
  logic             load;
  logic             in_take;

  logic [CNT_W-1:0] lead_full;
  logic [LEAD_W-1:0] lead;
  logic [PAT_W-1:0] rot;
  logic             wrap_tr;
  logic [CNT_W:0]   nruns_wide;
  logic [CNT_W-1:0] nruns;
  logic             ld_trunc;
  logic             ld_special;
  logic             ld_special_run;
  logic [OFS_W-1:0] ld_special_ofs;

  logic [CNT_W-1:0] lz_run;
  logic [CNT_W-1:0] gen_run;
  logic [RUN_W-1:0] cur_run;

  assign adv     = !out_valid || !out_stall;
  assign emit    = e_busy && adv;
  assign e_last  = e_fixed || (CNT_W'(e_idx) + CNT_W'(1) == e_count);
  assign e_done  = emit && e_last;
  assign load    = in_full && (!e_busy || e_done);
  assign in_stall = in_full && !load;
  assign in_take = in_valid && !in_stall;

  // Setup for a new pattern.
  assign lead_full = lead_zeros(in_pat);
  assign lead      = lead_full[LEAD_W-1:0];
  assign rot       = (in_pat << lead) | (in_pat >> (CNT_W'(PAT_W) - CNT_W'(lead)));

  // Run count is the circular transition count plus one, less the seam at the rotation point.
  assign wrap_tr    = !in_pat[PAT_W-1] || !in_pat[0];
  assign nruns_wide = {1'b0, ones(in_pat ^ {in_pat[PAT_W-2:0], in_pat[PAT_W-1]})}
                      + (CNT_W+1)'(1) - (CNT_W+1)'(wrap_tr);
  assign nruns      = nruns_wide[CNT_W-1:0];
  assign ld_trunc   = nruns > MAX_C;

  always_comb begin
    ld_special     = 1'b1;
    ld_special_run = 1'b0;
    ld_special_ofs = OFS_CLEAR;
    case (in_pat)
      PAT_CLEAR: begin
        ld_special_ofs = OFS_CLEAR;
      end
      PAT_SET: begin
        ld_special_ofs = OFS_SET;
      end
      PAT_DOT_ODD: begin
        ld_special_run = 1'b1;
        ld_special_ofs = OFS_DOT_ODD;
      end
      PAT_DOT_EVEN: begin
        ld_special_run = 1'b1;
        ld_special_ofs = OFS_DOT_EVEN;
      end
      default: begin
        ld_special = 1'b0;
      end
    endcase
  end

  // Current run: leading bits equal to the current level, bounded by bits left.
  assign lz_run  = lead_zeros(e_word ^ {PAT_W{e_cur}});
  assign gen_run = (lz_run < e_rem) ? lz_run : e_rem;
  assign cur_run = e_fixed ? RUN_W'(e_fixed_run) : RUN_W'(gen_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      e_busy    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        in_full <= 1'b1;
      end else if (load) begin
        in_full <= 1'b0;
      end
      if (load) begin
        e_busy <= 1'b1;
      end else if (e_done) begin
        e_busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_pat <= line_pattern;
    end
    if (load) begin
      e_fixed     <= ld_special;
      e_fixed_run <= ld_special_run;
      e_word      <= rot;
      e_cur       <= 1'b1;
      e_rem       <= CNT_W'(PAT_W);
      e_idx       <= '0;
      e_count     <= ld_special ? CNT_W'(ld_special_run) : (ld_trunc ? MAX_C : nruns);
      e_trunc     <= !ld_special && ld_trunc;
      e_offset    <= ld_special ? ld_special_ofs : (OFS_BASE - OFS_W'(lead));
    end else if (emit) begin
      e_word <= e_word << gen_run;
      e_rem  <= e_rem - gen_run;
      e_cur  <= !e_cur;
      e_idx  <= e_idx + IDX_W'(1);
    end
    if (emit) begin
      run_length    <= cur_run;
      dash_offset   <= e_offset;
      element_count <= e_count[CNT_OUT_W-1:0];
      truncated     <= e_trunc;
      last          <= e_last;
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    e_busy |-> e_rem <= CNT_W'(PAT_W))
    else $error("Run emitter has more bits left than a pattern holds.");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    (in_full && !e_busy) |=> e_busy)
    else $error("A waiting word was not moved into the run emitter.");

  a_zero_run_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && run_length == '0) |-> last)
    else $error("An empty run was not the final word of its pattern.");

  a_general_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    (emit && !e_fixed) |-> (gen_run != '0))
    else $error("A general pattern produced an empty run.");

endmodule
